### rtl/gpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpb_pkg
// Types, codes and helper functions shared by the particle step block.
// ----------------------------------------------------------------------------
package gpb_pkg;

    localparam int POS_W  = 16;
    localparam int VEL_W  = 24;
    localparam int FRAC_W = 16;
    localparam int MUL_W  = 27;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_GRAV = 2'd1;
    localparam logic [1:0] REQ_REV  = 2'd2;
    localparam logic [1:0] REQ_LOAD = 2'd3;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_GRAV   = 2'd3;

    // Softening term 0.001 in Q.20.
    localparam logic [53:0] EPS_Q20 = 54'd1049;

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef struct packed {
        logic [16:0]              adx;
        logic [16:0]              ady;
        logic                     neg_x;
        logic                     neg_y;
        logic [10:0]              rs;
        logic [23:0]              gconst;
        logic [23:0]              mass;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
    } t_grav_req;

    typedef struct packed {
        logic                     done;
        logic                     hit;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
    } t_grav_res;

    function automatic logic signed [VEL_W-1:0] f_neg_sat(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == VEL_MIN) begin
            r = VEL_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] f_add_sat(input logic signed [VEL_W-1:0] v,
                                                          input logic signed [25:0] a);
        logic signed [26:0] s;
        logic signed [VEL_W-1:0] r;
        s = 27'(v) + 27'(a);
        if (s > 27'(VEL_MAX)) begin
            r = VEL_MAX;
        end else if (s < 27'(VEL_MIN)) begin
            r = VEL_MIN;
        end else begin
            r = s[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/gpb_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpb_mul
// Shared unsigned 27x27 multiplier with a registered product.
// ----------------------------------------------------------------------------
module gpb_mul
    import gpb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [MUL_W-1:0]   i_a,
    input  wire logic [MUL_W-1:0]   i_b,
    output logic [2*MUL_W-1:0]      o_p
);

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### rtl/gpb_grav.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpb_grav
// Gravity sequencer: distance, collision test, square root, and the two
// acceleration divisions, all on one multiplier and one wide subtractor.
// ----------------------------------------------------------------------------
module gpb_grav
    import gpb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_grav_req  i_req,
    output t_grav_res       o_res,
    output logic            o_busy
);

    localparam logic [3:0] G_IDLE  = 4'd0;
    localparam logic [3:0] G_SQX   = 4'd1;
    localparam logic [3:0] G_SQY   = 4'd2;
    localparam logic [3:0] G_RS    = 4'd3;
    localparam logic [3:0] G_GM    = 4'd4;
    localparam logic [3:0] G_GMCAP = 4'd5;
    localparam logic [3:0] G_SQRT  = 4'd6;
    localparam logic [3:0] G_D0    = 4'd7;
    localparam logic [3:0] G_D1    = 4'd8;
    localparam logic [3:0] G_D2    = 4'd9;
    localparam logic [3:0] G_N0    = 4'd10;
    localparam logic [3:0] G_N1    = 4'd11;
    localparam logic [3:0] G_DIV   = 4'd12;
    localparam logic [3:0] G_ACC   = 4'd13;

    logic [3:0]         r_state;
    logic [4:0]         r_cnt;
    logic               r_comp;
    logic               r_done;
    t_grav_req          r_req;
    logic               r_hit;
    logic [33:0]        r_d2;
    logic [53:0]        r_dq;
    logic [47:0]        r_gm;
    logic [53:0]        r_res;
    logic [53:0]        r_bit;
    logic [80:0]        r_d;
    logic [105:0]       r_rem;
    logic [105:0]       r_dsh;
    logic [25:0]        r_q;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] p;
    logic [53:0]        sq_try;
    logic [105:0]       sub_b;
    logic [106:0]       diff;
    logic               ge;
    logic [16:0]        cur_d;
    logic [24:0]        mag;
    logic signed [25:0] acc;

    gpb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (p)
    );

    // Operands for the multiplier; the registered product is used in the next state.
    always_comb begin
        cur_d = r_comp ? r_req.ady : r_req.adx;
        unique case (r_state)
            G_SQX: begin
                mul_a = MUL_W'(r_req.adx);
                mul_b = MUL_W'(r_req.adx);
            end
            G_SQY: begin
                mul_a = MUL_W'(r_req.ady);
                mul_b = MUL_W'(r_req.ady);
            end
            G_RS: begin
                mul_a = MUL_W'(r_req.rs);
                mul_b = MUL_W'(r_req.rs);
            end
            G_GM: begin
                mul_a = MUL_W'(r_req.gconst);
                mul_b = MUL_W'(r_req.mass);
            end
            G_D0: begin
                mul_a = r_dq[26:0];
                mul_b = r_res[26:0];
            end
            G_D1: begin
                mul_a = r_dq[53:27];
                mul_b = r_res[26:0];
            end
            G_D2: begin
                mul_a = MUL_W'(r_gm[23:0]);
                mul_b = MUL_W'(r_req.adx);
            end
            G_N0: begin
                mul_a = MUL_W'(r_gm[47:24]);
                mul_b = MUL_W'(cur_d);
            end
            G_ACC: begin
                mul_a = MUL_W'(r_gm[23:0]);
                mul_b = MUL_W'(r_req.ady);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The one wide subtractor serves the square root and the division.
    always_comb begin
        sq_try = r_res + r_bit;
        sub_b  = (r_state == G_SQRT) ? {52'b0, sq_try} : r_dsh;
        diff   = {1'b0, r_rem} - {1'b0, sub_b};
        ge     = !diff[106];
        mag    = (r_q > 26'd16777216) ? 25'h1000000 : r_q[24:0];
        acc    = (r_comp ? r_req.neg_y : r_req.neg_x) ? -$signed({1'b0, mag})
                                                       : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_comp  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_comp  <= 1'b0;
                        r_state <= G_SQX;
                    end
                end
                G_SQX: r_state <= G_SQY;
                G_SQY: begin
                    r_d2    <= 34'(p);
                    r_state <= G_RS;
                end
                G_RS: begin
                    r_d2    <= r_d2 + 34'(p);
                    r_state <= G_GM;
                end
                G_GM: begin
                    r_hit   <= (54'(r_d2) < p);
                    r_dq    <= {r_d2, 20'b0} + EPS_Q20;
                    r_state <= G_GMCAP;
                end
                G_GMCAP: begin
                    r_gm    <= p[47:0];
                    r_rem   <= {52'b0, r_dq};
                    r_res   <= '0;
                    r_bit   <= 54'd1 << 52;
                    r_cnt   <= 5'd26;
                    r_state <= G_SQRT;
                end
                G_SQRT: begin
                    if (ge) begin
                        r_rem <= diff[105:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= G_D0;
                    end
                end
                G_D0: r_state <= G_D1;
                G_D1: begin
                    r_d     <= {27'b0, p};
                    r_state <= G_D2;
                end
                G_D2: begin
                    r_d     <= r_d + {p, 27'b0};
                    r_state <= G_N0;
                end
                G_N0: begin
                    r_rem   <= {38'b0, p, 14'b0};
                    r_state <= G_N1;
                end
                G_N1: begin
                    r_rem   <= r_rem + {14'b0, p, 38'b0};
                    r_dsh   <= {r_d, 25'b0};
                    r_q     <= '0;
                    r_cnt   <= 5'd25;
                    r_state <= G_DIV;
                end
                G_DIV: begin
                    if (ge) begin
                        r_rem <= diff[105:0];
                    end
                    r_q   <= {r_q[24:0], ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= G_ACC;
                    end
                end
                G_ACC: begin
                    if (!r_comp) begin
                        r_req.vel_x <= f_add_sat(r_req.vel_x, acc);
                        r_comp      <= 1'b1;
                        r_state     <= G_N0;
                    end else begin
                        r_req.vel_y <= f_add_sat(r_req.vel_y, acc);
                        r_done      <= 1'b1;
                        r_state     <= G_IDLE;
                    end
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    assign o_res.done  = r_done;
    assign o_res.hit   = r_hit;
    assign o_res.vel_x = r_req.vel_x;
    assign o_res.vel_y = r_req.vel_y;
    assign o_busy      = (r_state != G_IDLE);

endmodule
`default_nettype wire

### rtl/particle_gravity_bounce_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_gravity_bounce_step
// One particle's position and velocity, updated by tick, gravity, reverse
// and load words, with wall bounces and pairwise gravity.
// ----------------------------------------------------------------------------
// Tick, reverse and load words are accepted when the block is idle and the
// result is ready the next cycle. The sequencer runs a gravity word's squares
// and products on one 27x27 multiplier, then a 27-step square root and two
// 26-step divisions, one bit per cycle on one shared wide subtractor. No new
// word is accepted while a gravity word is in progress or while an unread
// result is held.
module particle_gravity_bounce_step
    import gpb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_req_type,
    input  wire logic signed [15:0]      i_x_arg,
    input  wire logic signed [15:0]      i_y_arg,
    input  wire logic [23:0]             i_mass_arg,
    input  wire logic [9:0]              i_radius_arg,
    input  wire logic signed [23:0]      i_vx_arg,
    input  wire logic signed [23:0]      i_vy_arg,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [15:0]           o_pos_x_out,
    output logic signed [15:0]           o_pos_y_out,
    output logic signed [23:0]           o_vel_x_out,
    output logic signed [23:0]           o_vel_y_out,
    output logic                         o_collided,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic T_IDLE = 1'b0;
    localparam logic T_BUSY = 1'b1;

    logic                    r_state;
    logic                    r_out_valid;
    logic [9:0]              r_radius;
    logic [11:0]             r_width;
    logic [11:0]             r_height;
    logic [23:0]             r_grav;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [VEL_W-1:0] r_vel_x;
    logic signed [VEL_W-1:0] r_vel_y;
    logic                    r_hit;

    logic                    in_acc;
    logic                    cfg_wr;
    logic                    grav_start;
    logic                    grav_busy;
    t_grav_req               greq;
    t_grav_res               gres;
    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    logic signed [17:0]      xs;
    logic signed [17:0]      ys;
    logic signed [17:0]      rr;
    logic signed [17:0]      ww;
    logic signed [17:0]      hh;
    logic signed [POS_W-1:0] n_pos_x;
    logic signed [POS_W-1:0] n_pos_y;
    logic signed [VEL_W-1:0] n_vel_x;
    logic signed [VEL_W-1:0] n_vel_y;

    // Position plus velocity, truncated toward zero to whole pixels.
    function automatic logic signed [17:0] f_advance(input logic signed [POS_W-1:0] pos,
                                                     input logic signed [VEL_W-1:0] vel);
        logic signed [32:0] s;
        s = $signed({pos[POS_W-1], pos, {FRAC_W{1'b0}}}) + 33'(vel);
        if (s[32]) begin
            s = s + 33'sd65535;
        end
        return 18'($signed(s[32:FRAC_W]));
    endfunction

    assign o_in_ready = (r_state == T_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign grav_start = in_acc && (i_req_type == REQ_GRAV);
    assign pready     = 1'b1;

    always_comb begin
        dx = 17'(i_x_arg) - 17'(r_pos_x);
        dy = 17'(i_y_arg) - 17'(r_pos_y);
        greq.adx    = dx[16] ? 17'(-dx) : 17'(dx);
        greq.ady    = dy[16] ? 17'(-dy) : 17'(dy);
        greq.neg_x  = dx[16];
        greq.neg_y  = dy[16];
        greq.rs     = 11'(r_radius) + 11'(i_radius_arg);
        greq.gconst = r_grav;
        greq.mass   = i_mass_arg;
        greq.vel_x  = r_vel_x;
        greq.vel_y  = r_vel_y;
    end

    gpb_grav u_grav (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (grav_start),
        .i_req   (greq),
        .o_res   (gres),
        .o_busy  (grav_busy)
    );

    // Tick: move, then bounce off the walls and clamp.
    always_comb begin
        xs = f_advance(r_pos_x, r_vel_x);
        ys = f_advance(r_pos_y, r_vel_y);
        rr = $signed({8'b0, r_radius});
        ww = $signed({6'b0, r_width});
        hh = $signed({6'b0, r_height});
        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        priority if (xs <= rr) begin
            n_vel_x = f_neg_sat(r_vel_x);
            n_pos_x = rr[POS_W-1:0];
        end else if (xs + rr > ww) begin
            n_vel_x = f_neg_sat(r_vel_x);
            n_pos_x = 16'(ww - rr);
        end else begin
            n_pos_x = xs[POS_W-1:0];
        end
        priority if (ys < rr) begin
            n_vel_y = f_neg_sat(r_vel_y);
            n_pos_y = rr[POS_W-1:0];
        end else if (ys + rr > hh) begin
            n_vel_y = f_neg_sat(r_vel_y);
            n_pos_y = 16'(hh - rr);
        end else begin
            n_pos_y = ys[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
            r_radius    <= 10'd10;
            r_width     <= 12'd1024;
            r_height    <= 12'd768;
            r_grav      <= 24'd65536;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_hit       <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_RADIUS: r_radius <= pwdata[9:0];
                    REG_WIDTH:  r_width  <= pwdata[11:0];
                    REG_HEIGHT: r_height <= pwdata[11:0];
                    REG_GRAV:   r_grav   <= pwdata[23:0];
                    default:    r_grav   <= r_grav;
                endcase
            end
            if (o_out_valid && i_out_ready && !in_acc) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_hit <= 1'b0;
                unique case (i_req_type)
                    REQ_TICK: begin
                        r_pos_x     <= n_pos_x;
                        r_pos_y     <= n_pos_y;
                        r_vel_x     <= n_vel_x;
                        r_vel_y     <= n_vel_y;
                        r_out_valid <= 1'b1;
                    end
                    REQ_GRAV: begin
                        r_state     <= T_BUSY;
                        r_out_valid <= 1'b0;
                    end
                    REQ_REV: begin
                        r_vel_x     <= f_neg_sat(r_vel_x);
                        r_vel_y     <= f_neg_sat(r_vel_y);
                        r_out_valid <= 1'b1;
                    end
                    REQ_LOAD: begin
                        r_pos_x     <= i_x_arg;
                        r_pos_y     <= i_y_arg;
                        r_vel_x     <= i_vx_arg;
                        r_vel_y     <= i_vy_arg;
                        r_out_valid <= 1'b1;
                    end
                    default: r_out_valid <= 1'b1;
                endcase
            end
            // The output slot is always empty by the time gravity finishes.
            if (r_state == T_BUSY && gres.done) begin
                r_vel_x     <= gres.vel_x;
                r_vel_y     <= gres.vel_y;
                r_hit       <= gres.hit;
                r_out_valid <= 1'b1;
                r_state     <= T_IDLE;
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = {22'b0, r_radius};
            REG_WIDTH:  prdata = {20'b0, r_width};
            REG_HEIGHT: prdata = {20'b0, r_height};
            REG_GRAV:   prdata = {8'b0, r_grav};
            default:    prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x_out = r_pos_x;
    assign o_pos_y_out = r_pos_y;
    assign o_vel_x_out = r_vel_x;
    assign o_vel_y_out = r_vel_y;
    assign o_collided  = r_hit;

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_BUSY) |-> !r_out_valid)
        else $error("result held while gravity word in progress");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gres.done |-> (r_state == T_BUSY))
        else $error("gravity unit finished with no word in progress");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grav_start |-> !grav_busy)
        else $error("gravity word started while unit busy");

    a_hit_grav_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type != REQ_GRAV) |=> !o_collided)
        else $error("collision flag set on a non-gravity result");

endmodule
`default_nettype wire

### tb/particle_gravity_bounce_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_gravity_bounce_step_tb
// Drives tick, gravity, reverse and load words into the particle step block.
// A behavioral model of the particle predicts each result word, and every
// result is checked field by field. Register settings change between phases,
// and in the later phases the sender, the receiver or both idle at random.
// ----------------------------------------------------------------------------
module particle_gravity_bounce_step_tb;
    import gpb_pkg::*;

    localparam int HALF_HI      = 4;
    localparam int HALF_LO      = 4;
    localparam int STALL_LIMIT  = 20000;
    localparam longint ACC_CAP  = 64'd16777216;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [23:0]        mass;
        logic [9:0]         rad;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
    } t_word;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               hit;
    } t_state;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_req_type;
    logic signed [15:0]  i_x_arg;
    logic signed [15:0]  i_y_arg;
    logic [23:0]         i_mass_arg;
    logic [9:0]          i_radius_arg;
    logic signed [23:0]  i_vx_arg;
    logic signed [23:0]  i_vy_arg;
    logic                o_out_valid;
    logic                i_out_ready;
    logic signed [15:0]  o_pos_x_out;
    logic signed [15:0]  o_pos_y_out;
    logic signed [23:0]  o_vel_x_out;
    logic signed [23:0]  o_vel_y_out;
    logic                o_collided;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Model copy of the particle and its registers.
    logic signed [15:0]  part_px, part_py;
    logic signed [23:0]  part_vx, part_vy;
    logic [9:0]          cfg_radius;
    logic [11:0]         cfg_width, cfg_height;
    logic [23:0]         cfg_grav;

    t_state              pending_states[$];
    int                  mismatches;
    int                  quiet_cycles;
    int                  sender_idle_pct;
    int                  receiver_stall_pct;

    particle_gravity_bounce_step dut (.*);

    always begin
        i_clk = 1'b1;
        #HALF_HI;
        i_clk = 1'b0;
        #HALF_LO;
    end

    function automatic longint sat_vel(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // One axis of the pull: floor(G*m*|d|*2^14 / (Dq*rq)), capped at 2^24.
    function automatic longint pull_axis(input logic [63:0] gm, input longint delta,
                                         input logic [63:0] dq, input logic [63:0] rq);
        logic [127:0] num, den, quo;
        logic [63:0]  mag;
        mag = (delta < 0) ? 64'(-delta) : 64'(delta);
        num = 128'(gm) * 128'(mag << 14);
        den = 128'(dq) * 128'(rq);
        quo = num / den;
        if (quo > 128'(ACC_CAP)) quo = 128'(ACC_CAP);
        return (delta < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic t_state step_particle(input t_word w);
        t_state      res;
        longint      r, x, y, s, dx, dy, d2, rs;
        logic [63:0] gm, dq, rq;
        r   = longint'(cfg_radius);
        res.hit = 1'b0;
        case (w.kind)
            REQ_TICK: begin
                s = longint'(part_px) * 65536 + longint'(part_vx);
                x = s / 65536;
                s = longint'(part_py) * 65536 + longint'(part_vy);
                y = s / 65536;
                if (x - r <= 0) begin
                    part_vx = 24'(sat_vel(-longint'(part_vx)));
                    x = r;
                end else if (x + r > longint'(cfg_width)) begin
                    part_vx = 24'(sat_vel(-longint'(part_vx)));
                    x = longint'(cfg_width) - r;
                end
                if (y - r < 0) begin
                    part_vy = 24'(sat_vel(-longint'(part_vy)));
                    y = r;
                end else if (y + r > longint'(cfg_height)) begin
                    part_vy = 24'(sat_vel(-longint'(part_vy)));
                    y = longint'(cfg_height) - r;
                end
                part_px = x[15:0];
                part_py = y[15:0];
            end
            REQ_GRAV: begin
                dx = longint'(w.x) - longint'(part_px);
                dy = longint'(w.y) - longint'(part_py);
                d2 = dx * dx + dy * dy;
                rs = longint'(cfg_radius) + longint'(w.rad);
                res.hit = (d2 < rs * rs);
                gm = 64'(cfg_grav) * 64'(w.mass);
                dq = (64'(d2) << 20) + 64'd1049;
                rq = int_sqrt(dq);
                part_vx = 24'(sat_vel(longint'(part_vx) + pull_axis(gm, dx, dq, rq)));
                part_vy = 24'(sat_vel(longint'(part_vy) + pull_axis(gm, dy, dq, rq)));
            end
            REQ_REV: begin
                part_vx = 24'(sat_vel(-longint'(part_vx)));
                part_vy = 24'(sat_vel(-longint'(part_vy)));
            end
            default: begin
                part_px = w.x;
                part_py = w.y;
                part_vx = w.vx;
                part_vy = w.vy;
            end
        endcase
        res.px = part_px;
        res.py = part_py;
        res.vx = part_vx;
        res.vy = part_vy;
        return res;
    endfunction

    // Receiver stalls at random; the rate is set per phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_state want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_states.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                mismatches++;
            end else begin
                want = pending_states.pop_front();
                if (o_pos_x_out !== want.px) begin
                    $display("%0t: pos_x exp %0d got %0d", $time, want.px, o_pos_x_out);
                    mismatches++;
                end
                if (o_pos_y_out !== want.py) begin
                    $display("%0t: pos_y exp %0d got %0d", $time, want.py, o_pos_y_out);
                    mismatches++;
                end
                if (o_vel_x_out !== want.vx) begin
                    $display("%0t: vel_x exp %0d got %0d", $time, want.vx, o_vel_x_out);
                    mismatches++;
                end
                if (o_vel_y_out !== want.vy) begin
                    $display("%0t: vel_y exp %0d got %0d", $time, want.vy, o_vel_y_out);
                    mismatches++;
                end
                if (o_collided !== want.hit) begin
                    $display("%0t: collided exp %0b got %0b", $time, want.hit, o_collided);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which no word is accepted and no result is taken.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("particle_gravity_bounce_step_tb failed");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the accepting edge
    // with valid still high, so back-to-back words need no extra assignment.
    task automatic send_word(input t_word w);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= w.kind;
        i_x_arg      <= w.x;
        i_y_arg      <= w.y;
        i_mass_arg   <= w.mass;
        i_radius_arg <= w.rad;
        i_vx_arg     <= w.vx;
        i_vy_arg     <= w.vy;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_states.push_back(step_particle(w));
    endtask

    task automatic send_fields(input logic [1:0] kind, input int x, input int y,
                               input int mass, input int rad, input int vx, input int vy);
        t_word w;
        w.kind = kind;
        w.x    = 16'(x);
        w.y    = 16'(y);
        w.mass = 24'(mass);
        w.rad  = 10'(rad);
        w.vx   = 24'(vx);
        w.vy   = 24'(vy);
        send_word(w);
    endtask

    // Lower valid, let every result drain, then give the block a margin.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_states.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS: cfg_radius = value[9:0];
            REG_WIDTH:  cfg_width  = value[11:0];
            REG_HEIGHT: cfg_height = value[11:0];
            default:    cfg_grav   = value[23:0];
        endcase
    endtask

    task automatic set_regs(input int rad, input int wid, input int hgt, input int g);
        write_reg(REG_RADIUS, 32'(rad));
        write_reg(REG_WIDTH, 32'(wid));
        write_reg(REG_HEIGHT, 32'(hgt));
        write_reg(REG_GRAV, 32'(g));
    endtask

    task automatic test_directed_words();
        // Start at the origin: the left and top walls reflect a still particle.
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_LOAD, 32767, -32768, 0, 1023, 8388607, -8388608);
        // Negating the most negative velocity saturates.
        send_fields(REQ_REV, -1, -1, 16777215, 1023, -1, -1);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_LOAD, -32768, 32767, 0, 0, -8388608, 8388607);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        // Truncation toward zero with negative and positive fractions.
        send_fields(REQ_LOAD, 100, 100, 0, 0, -98304, 98304);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_LOAD, 100, 100, 0, 0, 0, 0);
        // Coincident particles give no pull but do collide.
        send_fields(REQ_GRAV, 100, 100, 16777215, 1023, 0, 0);
        // Overlap boundary: distance equal to the radius sum is no collision.
        send_fields(REQ_GRAV, 120, 100, 65536, 10, 0, 0);
        send_fields(REQ_GRAV, 119, 100, 65536, 10, 0, 0);
        // Offsets of one pixel on each axis with the largest mass.
        send_fields(REQ_GRAV, 101, 99, 16777215, 0, 0, 0);
        send_fields(REQ_GRAV, -32768, 32767, 16777215, 1023, 0, 0);
        send_fields(REQ_GRAV, 32767, -32768, 0, 0, 0, 0);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        drain_block();
        // Walls narrower than the particle: the clamp to the radius has priority.
        set_regs(1023, 1, 1, 16777215);
        send_fields(REQ_LOAD, 500, 500, 0, 0, 65536, -65536);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_GRAV, 0, 0, 16777215, 1023, 0, 0);
        drain_block();
        set_regs(1, 4095, 4095, 0);
        send_fields(REQ_LOAD, 4094, 4094, 0, 0, 8388607, 8388607);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        send_fields(REQ_GRAV, 0, 0, 16777215, 0, 0, 0);
        send_fields(REQ_TICK, 0, 0, 0, 0, 0, 0);
        drain_block();
    endtask

    task automatic test_random_words(input int count);
        t_word w;
        int    pick;
        for (int n = 0; n < count; n++) begin
            w.kind = REQ_TICK;
            w.x    = 16'($urandom);
            w.y    = 16'($urandom);
            w.mass = 24'($urandom);
            w.rad  = 10'($urandom);
            w.vx   = 24'($urandom);
            w.vy   = 24'($urandom);
            pick   = $urandom_range(99);
            if (pick < 35) begin
                w.kind = REQ_TICK;
            end else if (pick < 70) begin
                w.kind = REQ_GRAV;
                if ($urandom_range(99) < 85) begin
                    w.x = 16'(int'(part_px) + $urandom_range(400) - 200);
                    w.y = 16'(int'(part_py) + $urandom_range(400) - 200);
                    w.rad = 10'($urandom_range(60));
                end
            end else if (pick < 80) begin
                w.kind = REQ_REV;
            end else begin
                w.kind = REQ_LOAD;
                if ($urandom_range(99) < 80) begin
                    w.x  = 16'($urandom_range(int'(cfg_width)));
                    w.y  = 16'($urandom_range(int'(cfg_height)));
                    w.vx = 24'(int'($urandom_range(2000000)) - 1000000);
                    w.vy = 24'(int'($urandom_range(2000000)) - 1000000);
                end
            end
            send_word(w);
        end
        drain_block();
    endtask

    task automatic test_random_regs();
        set_regs($urandom_range(1, 40), $urandom_range(200, 4095),
                 $urandom_range(200, 4095), $urandom_range(0, 16777215));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_req_type         = REQ_TICK;
        i_x_arg            = '0;
        i_y_arg            = '0;
        i_mass_arg         = '0;
        i_radius_arg       = '0;
        i_vx_arg           = '0;
        i_vy_arg           = '0;
        i_out_ready        = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        mismatches         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        part_px            = '0;
        part_py            = '0;
        part_vx            = '0;
        part_vy            = '0;
        cfg_radius         = 10'd10;
        cfg_width          = 12'd1024;
        cfg_height         = 12'd768;
        cfg_grav           = 24'd65536;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_words();
        set_regs(10, 1024, 768, 65536);
        test_random_words(350);
        sender_idle_pct = 58;
        test_random_regs();
        test_random_words(350);
        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        test_random_regs();
        test_random_words(350);
        sender_idle_pct    = 24;
        receiver_stall_pct = 24;
        set_regs(1023, 4095, 4095, 16777215);
        test_random_words(100);
        test_random_regs();
        test_random_words(250);

        if (mismatches == 0) begin
            $display("particle_gravity_bounce_step_tb passed");
        end else begin
            $display("particle_gravity_bounce_step_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gpb_pkg.sv
rtl/gpb_mul.sv
rtl/gpb_grav.sv
rtl/particle_gravity_bounce_step.sv
tb/particle_gravity_bounce_step_tb.sv
